>>> src/ertr_pkg.sv
// ============================================================================
// ertr_pkg
// Shared constants, codes and controller/datapath interface types for the
// relative-return tracker.
// ============================================================================
package ertr_pkg;

    // Number formats
    localparam int PRICE_BITS   = 32;                       // integer price bits kept
    localparam int FRAC_BITS    = 16;                       // average fraction bits
    localparam int AVG_BITS     = PRICE_BITS + FRAC_BITS;   // average width (max 48)
    localparam int PRICE_IN_BITS = 32;                      // price port width
    localparam int SID_BITS     = 16;
    localparam int SPREAD_BITS  = 16;
    localparam int DECAY_BITS   = 16;                       // Q0.16 weight
    localparam int W_BITS       = DECAY_BITS + 1;           // weight incl. 1.0
    localparam int Q_SHIFT      = 16;                       // blend scale 2^16

    // Blend multiply is split into 24-bit chunks
    localparam int CHUNK_BITS   = 24;
    localparam int HI_BITS      = AVG_BITS - CHUNK_BITS;
    localparam int PROD_BITS    = CHUNK_BITS + W_BITS;
    localparam int ACC_BITS     = PROD_BITS + 1;
    localparam int BLEND_SHIFT  = CHUNK_BITS - Q_SHIFT;
    localparam int BLEND_BITS   = ACC_BITS + BLEND_SHIFT;

    // Return format, Q2.30
    localparam int RET_BITS     = 32;
    localparam int DIV_STEPS    = 30;
    localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);

    localparam logic [W_BITS-1:0]     ONE_Q16     = W_BITS'(1) << Q_SHIFT;
    localparam logic [RET_BITS-1:0]   RET_MAX     = {1'b0, {(RET_BITS-1){1'b1}}};
    localparam logic [DECAY_BITS-1:0] DECAY_RESET = DECAY_BITS'(52016);

    // Event kinds
    typedef enum logic [1:0] {
        MODE_UPDATE = 2'd0,
        MODE_INTR   = 2'd1,
        MODE_RESUME = 2'd2,
        MODE_UNUSED = 2'd3
    } mode_t;

    // Configuration register indexes
    typedef enum logic {
        CFG_DECAY = 1'b0,
        CFG_WATCH = 1'b1
    } cfg_idx_t;

    // Blend partial products, in issue order
    typedef enum logic [1:0] {
        MUL_P_HI = 2'd0,
        MUL_A_HI = 2'd1,
        MUL_P_LO = 2'd2,
        MUL_A_LO = 2'd3
    } mul_step_t;

    // Datapath operations
    typedef enum logic [3:0] {
        OP_NONE   = 4'd0,
        OP_LOAD   = 4'd1,
        OP_EXEC   = 4'd2,
        OP_MUL    = 4'd3,
        OP_BLEND  = 4'd4,
        OP_PREP_A = 4'd5,
        OP_PREP_B = 4'd6,
        OP_DIV    = 4'd7,
        OP_FIN    = 4'd8,
        OP_EMIT   = 4'd9
    } dp_op_t;

    typedef struct packed {
        dp_op_t    op;
        mul_step_t step;
    } dp_cmd_t;

    typedef struct packed {
        logic compute;   // update that runs the average and divide
        logic emits;     // request produces a result
        logic special;   // zero average or clipped return
    } dp_status_t;

endpackage

>>> src/ertr_ctrl.sv
// ============================================================================
// ertr_ctrl
// Sequencer for the tracker: decodes each request, steps the shared
// multiplier and the serial divider, and owns the output valid flag.
// ============================================================================
module ertr_ctrl
    import ertr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       out_stall,
    output logic       out_valid,
    output dp_cmd_t    cmd,
    input  dp_status_t status
);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_DECODE = 9'b000000010,
        S_MUL    = 9'b000000100,
        S_BLEND  = 9'b000001000,
        S_PREP_A = 9'b000010000,
        S_PREP_B = 9'b000100000,
        S_DIV    = 9'b001000000,
        S_FIN    = 9'b010000000,
        S_EMIT   = 9'b100000000
    } state_t;

    state_t                  state_reg, state_next;
    mul_step_t               step_reg, step_next;
    logic [DIV_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                    out_valid_reg, out_valid_next;

    // Next state and command
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg & out_stall;
        cmd.op         = OP_NONE;
        cmd.step       = step_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.op = OP_EXEC;
                if (status.compute)
                begin
                    step_next  = MUL_P_HI;
                    state_next = S_MUL;
                end
                else if (status.emits)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_MUL:
            begin
                cmd.op = OP_MUL;
                if (step_reg == MUL_A_LO)
                begin
                    state_next = S_BLEND;
                end
                else
                begin
                    step_next = mul_step_t'(step_reg + 2'd1);
                end
            end
            S_BLEND:
            begin
                cmd.op     = OP_BLEND;
                state_next = S_PREP_A;
            end
            S_PREP_A:
            begin
                cmd.op     = OP_PREP_A;
                state_next = S_PREP_B;
            end
            S_PREP_B:
            begin
                cmd.op     = OP_PREP_B;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                // special cases skip the long division
                if (status.special)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.op = OP_DIV;
                    if (cnt_reg == DIV_CNT_BITS'(DIV_STEPS - 1))
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            S_FIN:
            begin
                cmd.op     = OP_FIN;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                // wait until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.op         = OP_EMIT;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= MUL_P_HI;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

>>> src/ertr_dp.sv
// ============================================================================
// ertr_dp
// Datapath: configuration and tracker state, chunked EMA blend on one
// shared multiplier, restoring divider for the Q2.30 return.
// ============================================================================
module ertr_dp
    import ertr_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  dp_cmd_t                     cmd,
    output dp_status_t                  status,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [DECAY_BITS-1:0]       cfg_data,
    input  logic [1:0]                  mode,
    input  logic [SID_BITS-1:0]         instrument_id,
    input  logic [PRICE_IN_BITS-1:0]    price,
    input  logic                        view_ready,
    input  logic [SPREAD_BITS-1:0]      spread_ticks,
    input  logic [SPREAD_BITS-1:0]      normal_spread_ticks,
    output logic signed [RET_BITS-1:0]  return_value,
    output logic                        saturated
);

    // Configuration and tracker state (reset)
    logic [DECAY_BITS-1:0] decay_reg, decay_next;
    logic [SID_BITS-1:0]   watch_reg, watch_next;
    logic                  armed_reg, armed_next;
    logic                  halted_reg, halted_next;
    logic [AVG_BITS-1:0]   avg_reg, avg_next;
    logic [PRICE_BITS-1:0] last_reg, last_next;
    logic [RET_BITS-1:0]   held_reg, held_next;

    // Request latch and working registers (no reset)
    logic [1:0]             mode_reg, mode_next;
    logic [SID_BITS-1:0]    sec_reg, sec_next;
    logic [PRICE_BITS-1:0]  price_reg, price_next;
    logic                   ready_reg, ready_next;
    logic [SPREAD_BITS-1:0] spread_reg, spread_next;
    logic [SPREAD_BITS-1:0] normal_reg, normal_next;
    logic [ACC_BITS-1:0]    hi_acc_reg, hi_acc_next;
    logic [ACC_BITS-1:0]    lo_acc_reg, lo_acc_next;
    logic                   neg_reg, neg_next;
    logic                   zero_reg, zero_next;
    logic [AVG_BITS-1:0]    n_reg, n_next;
    logic                   special_reg, special_next;
    logic [AVG_BITS-1:0]    rem_reg, rem_next;
    logic [RET_BITS-1:0]    q_reg, q_next;
    logic                   sat_reg, sat_next;
    logic [RET_BITS-1:0]    ret_out_reg, ret_out_next;
    logic                   sat_out_reg, sat_out_next;

    // Combinational helpers
    logic [AVG_BITS-1:0]   p_full;
    logic [W_BITS-1:0]     w_new, w_old;
    logic [CHUNK_BITS-1:0] mul_x;
    logic [W_BITS-1:0]     mul_w;
    logic [PROD_BITS-1:0]  mul_prod;
    logic [BLEND_BITS-1:0] blend_sum;
    logic                  is_update, intr_match, res_match, arm_ok;
    logic                  over, q0;
    logic [AVG_BITS:0]     rem_shift, rem_diff;
    logic                  rem_ge;

    assign p_full = {price_reg, {FRAC_BITS{1'b0}}};
    assign w_old  = {1'b0, decay_reg};
    assign w_new  = ONE_Q16 - w_old;

    // Request decode
    assign is_update  = (mode_reg == MODE_UPDATE);
    assign intr_match = (mode_reg == MODE_INTR) && (sec_reg == watch_reg);
    assign res_match  = (mode_reg == MODE_RESUME) && (sec_reg == watch_reg);
    assign arm_ok     = ready_reg && ({1'b0, spread_reg} < {normal_reg, 1'b0});

    assign status.compute = is_update && armed_reg && !halted_reg;
    assign status.emits   = is_update || intr_match;
    assign status.special = special_reg;

    // Shared multiplier operand select
    always_comb
    begin
        case (cmd.step)
            MUL_P_HI:
            begin
                mul_x = CHUNK_BITS'(p_full[AVG_BITS-1:CHUNK_BITS]);
                mul_w = w_new;
            end
            MUL_A_HI:
            begin
                mul_x = CHUNK_BITS'(avg_reg[AVG_BITS-1:CHUNK_BITS]);
                mul_w = w_old;
            end
            MUL_P_LO:
            begin
                mul_x = p_full[CHUNK_BITS-1:0];
                mul_w = w_new;
            end
            MUL_A_LO:
            begin
                mul_x = avg_reg[CHUNK_BITS-1:0];
                mul_w = w_old;
            end
            default:
            begin
                mul_x = '0;
                mul_w = '0;
            end
        endcase
    end

    assign mul_prod  = mul_x * mul_w;
    assign blend_sum = {hi_acc_reg, {BLEND_SHIFT{1'b0}}}
                     + BLEND_BITS'(lo_acc_reg >> Q_SHIFT);

    // Divider compare terms
    assign over      = ({1'b0, n_reg} >= {avg_reg, 1'b0});
    assign q0        = (n_reg >= avg_reg);
    assign rem_shift = {rem_reg, 1'b0};
    assign rem_diff  = rem_shift - {1'b0, avg_reg};
    assign rem_ge    = (rem_shift >= {1'b0, avg_reg});

    // Next-value logic by operation
    always_comb
    begin
        decay_next   = decay_reg;
        watch_next   = watch_reg;
        armed_next   = armed_reg;
        halted_next  = halted_reg;
        avg_next     = avg_reg;
        last_next    = last_reg;
        held_next    = held_reg;
        mode_next    = mode_reg;
        sec_next     = sec_reg;
        price_next   = price_reg;
        ready_next   = ready_reg;
        spread_next  = spread_reg;
        normal_next  = normal_reg;
        hi_acc_next  = hi_acc_reg;
        lo_acc_next  = lo_acc_reg;
        neg_next     = neg_reg;
        zero_next    = zero_reg;
        n_next       = n_reg;
        special_next = special_reg;
        rem_next     = rem_reg;
        q_next       = q_reg;
        sat_next     = sat_reg;
        ret_out_next = ret_out_reg;
        sat_out_next = sat_out_reg;

        // configuration writes must only arrive while idle; the block itself does not enforce it
        if (cfg_we)
        begin
            if (cfg_index == CFG_DECAY)
            begin
                decay_next = cfg_data;
            end
            else
            begin
                watch_next = cfg_data;
            end
        end

        case (cmd.op)
            OP_LOAD:
            begin
                mode_next   = mode;
                sec_next    = instrument_id;
                price_next  = PRICE_BITS'(price);
                ready_next  = view_ready;
                spread_next = spread_ticks;
                normal_next = normal_spread_ticks;
            end
            OP_EXEC:
            begin
                sat_next = 1'b0;
                if (is_update)
                begin
                    last_next = price_reg;
                    if (!armed_reg && arm_ok)
                    begin
                        armed_next = 1'b1;
                        avg_next   = p_full;
                        held_next  = '0;
                    end
                end
                if (intr_match)
                begin
                    halted_next = 1'b1;
                    held_next   = '0;
                end
                if (res_match)
                begin
                    held_next   = '0;
                    avg_next    = {last_reg, {FRAC_BITS{1'b0}}};
                    halted_next = 1'b0;
                end
            end
            OP_MUL:
            begin
                case (cmd.step)
                    MUL_P_HI: hi_acc_next = ACC_BITS'(mul_prod);
                    MUL_A_HI: hi_acc_next = hi_acc_reg + ACC_BITS'(mul_prod);
                    MUL_P_LO: lo_acc_next = ACC_BITS'(mul_prod);
                    MUL_A_LO: lo_acc_next = lo_acc_reg + ACC_BITS'(mul_prod);
                    default:  hi_acc_next = hi_acc_reg;
                endcase
            end
            OP_BLEND:
            begin
                avg_next = blend_sum[AVG_BITS-1:0];
            end
            OP_PREP_A:
            begin
                // sign and magnitude of price minus average
                neg_next  = (p_full < avg_reg);
                n_next    = (p_full < avg_reg) ? (avg_reg - p_full) : (p_full - avg_reg);
                zero_next = (avg_reg == '0);
            end
            OP_PREP_B:
            begin
                // integer quotient bit; a zero average or a return of 2.0 or more is special (clips)
                special_next = zero_reg || over;
                rem_next     = q0 ? (n_reg - avg_reg) : n_reg;
                q_next       = {{(RET_BITS-1){1'b0}}, q0};
            end
            OP_DIV:
            begin
                rem_next = rem_ge ? rem_diff[AVG_BITS-1:0] : rem_shift[AVG_BITS-1:0];
                q_next   = {q_reg[RET_BITS-2:0], rem_ge};
            end
            OP_FIN:
            begin
                if (special_reg)
                begin
                    held_next = (zero_reg && (n_reg == '0)) ? '0 : RET_MAX;
                    sat_next  = 1'b1;
                end
                else
                begin
                    held_next = neg_reg ? (RET_BITS'(0) - q_reg) : q_reg;
                    sat_next  = 1'b0;
                end
            end
            OP_EMIT:
            begin
                ret_out_next = held_reg;
                sat_out_next = sat_reg;
            end
            default:
            begin
                sat_next = sat_reg;
            end
        endcase
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decay_reg  <= DECAY_RESET;
            watch_reg  <= '0;
            armed_reg  <= 1'b0;
            halted_reg <= 1'b0;
            avg_reg    <= '0;
            last_reg   <= '0;
            held_reg   <= '0;
        end
        else
        begin
            decay_reg  <= decay_next;
            watch_reg  <= watch_next;
            armed_reg  <= armed_next;
            halted_reg <= halted_next;
            avg_reg    <= avg_next;
            last_reg   <= last_next;
            held_reg   <= held_next;
        end
    end

    // Payload and working registers
    always_ff @(posedge clk)
    begin
        mode_reg    <= mode_next;
        sec_reg     <= sec_next;
        price_reg   <= price_next;
        ready_reg   <= ready_next;
        spread_reg  <= spread_next;
        normal_reg  <= normal_next;
        hi_acc_reg  <= hi_acc_next;
        lo_acc_reg  <= lo_acc_next;
        neg_reg     <= neg_next;
        zero_reg    <= zero_next;
        n_reg       <= n_next;
        special_reg <= special_next;
        rem_reg     <= rem_next;
        q_reg       <= q_next;
        sat_reg     <= sat_next;
        ret_out_reg <= ret_out_next;
        sat_out_reg <= sat_out_next;
    end

    assign return_value = signed'(ret_out_reg);
    assign saturated    = sat_out_reg;

endmodule

>>> src/ema_relative_return_tracker.sv
// ============================================================================
// ema_relative_return_tracker
// Tracks an EMA of a price stream and reports (price - avg) / avg in Q2.30.
//
// Usage:
//   Input channel (in_valid / in_stall) takes one request: a market update,
//   a data-interrupted or a data-resumed event. in_stall is high from the
//   cycle after acceptance until the request is finished.
//   Output channel (out_valid / out_stall) carries return_value and
//   saturated. Updates and matching interrupts give one result; resumes,
//   interrupts for other securities and the unused mode give none.
//   Config channel (cfg_valid / cfg_ready, always ready): the user writes
//   decay_factor (index 0) and watched_security (index 1) only while idle; the block does not enforce it.
// Sequence:
//   An armed, running update steps through decode, four passes of the
//   24x17 multiplier, blend, divide set-up (sign and magnitude, then
//   integer quotient bit), 30 restoring divider steps, finish, emit. A
//   zero average or a clipped return skips the divider steps. Holding,
//   arming and interrupt requests go from decode straight to emit. One
//   request is in flight; the next is taken the cycle after a result is
//   loaded, or after decode when nothing is emitted.
// Reset: not armed, not halted, zero average. A stalled receiver holds the
// result; the next result waits in the block and blocks the input.
// ============================================================================
module ema_relative_return_tracker
    import ertr_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [1:0]                  mode,
    input  logic [SID_BITS-1:0]         instrument_id,
    input  logic [PRICE_IN_BITS-1:0]    price,
    input  logic                        view_ready,
    input  logic [SPREAD_BITS-1:0]      spread_ticks,
    input  logic [SPREAD_BITS-1:0]      normal_spread_ticks,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [RET_BITS-1:0]  return_value,
    output logic                        saturated,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic                        cfg_index,
    input  logic [DECAY_BITS-1:0]       cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    ertr_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .cmd       (cmd),
        .status    (status)
    );

    ertr_dp u_dp
    (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cmd                 (cmd),
        .status              (status),
        .cfg_we              (cfg_valid & cfg_ready),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .mode                (mode),
        .instrument_id       (instrument_id),
        .price               (price),
        .view_ready          (view_ready),
        .spread_ticks        (spread_ticks),
        .normal_spread_ticks (normal_spread_ticks),
        .return_value        (return_value),
        .saturated           (saturated)
    );

    // An accepted request blocks the input on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not blocked after request acceptance");

    // A new result is only produced while a request is being worked
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without a request in flight");

    // Saturated results are either full scale or zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |-> (return_value == signed'(RET_MAX) || return_value == 0))
        else $error("saturated result has an unexpected value");

endmodule
